// ----- hw/rtl/tlvd_pkg.sv -----
// ----------------------------------------------------------------------------
// tlvd_pkg
// Shared constants, queue word type and opcodes for the TLV deframer.
// ----------------------------------------------------------------------------
package tlvd_pkg;

	localparam int BYTE_W       = 8;
	localparam int TYPE_BYTES   = 2;
	localparam int LENGTH_BYTES = 4;
	localparam int HDR_BYTES    = TYPE_BYTES + LENGTH_BYTES;
	localparam int IDX_W        = 3;
	localparam int TYPE_W       = 16;
	localparam int LEN_W        = 32;
	localparam int CFG_W        = 16;
	localparam int CFG_RESET    = 4096;

	// type bytes past the width of frame_type are dropped
	localparam int TYPE_KEEP = (TYPE_BYTES < TYPE_W / BYTE_W) ? TYPE_BYTES : TYPE_W / BYTE_W;

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	localparam logic KIND_HDR = 1'b0;
	localparam logic KIND_VAL = 1'b1;

	typedef enum logic [1:0] {
		OP_HDR,
		OP_HDR_END,
		OP_VAL,
		OP_VAL_LAST
	} op_t;

	// one classified byte, front to back
	typedef struct packed {
		op_t               op;
		logic [IDX_W-1:0]  idx;
		logic [BYTE_W-1:0] data;
		logic [LEN_W-1:0]  len;
	} entry_t;

	typedef struct packed {
		logic   push;
		entry_t entry;
	} q_wr_t;

	typedef struct packed {
		logic   not_empty;
		entry_t entry;
	} q_rd_t;

endpackage

// ----- hw/rtl/tlvd_front.sv -----
// ----------------------------------------------------------------------------
// tlvd_front
// Accepts stream bytes, tracks header position and value count, classifies.
// ----------------------------------------------------------------------------
module tlvd_front (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	input  logic [tlvd_pkg::BYTE_W-1:0] rx_byte,
	input  logic                        q_full,
	output tlvd_pkg::q_wr_t             q_wr
);
	import tlvd_pkg::*;

	logic             in_value_q, in_value_d;
	logic [IDX_W-1:0] hdr_idx_q, hdr_idx_d;
	logic [LEN_W-1:0] len_q, len_d;
	logic [LEN_W-1:0] left_q, left_d;
	logic             accept;
	entry_t           ent;

	assign accept = in_valid && !q_full;

	always_comb begin
		logic [LEN_W-1:0] len_base;
		logic [LEN_W-1:0] left_dec;
		in_value_d = in_value_q;
		hdr_idx_d  = hdr_idx_q;
		len_d      = len_q;
		left_d     = left_q;
		left_dec   = left_q - LEN_W'(1);
		len_base   = (hdr_idx_q == '0) ? '0 : len_q;
		for (int k = 0; k < LENGTH_BYTES; k++) begin
			if (hdr_idx_q == IDX_W'(TYPE_BYTES + k)) begin
				len_base[k*BYTE_W +: BYTE_W] = rx_byte;
			end
		end
		ent.idx  = hdr_idx_q;
		ent.data = rx_byte;
		ent.len  = len_base;
		ent.op   = OP_HDR;
		if (in_value_q) begin
			left_d = left_dec;
			if (left_dec == '0) begin
				ent.op     = OP_VAL_LAST;
				in_value_d = 1'b0;
				hdr_idx_d  = '0;
			end else begin
				ent.op = OP_VAL;
			end
		end else begin
			len_d = len_base;
			if (hdr_idx_q == IDX_W'(HDR_BYTES - 1)) begin
				ent.op    = OP_HDR_END;
				hdr_idx_d = '0;
				if (len_base != '0) begin
					in_value_d = 1'b1;
					left_d     = len_base;
				end
			end else begin
				hdr_idx_d = hdr_idx_q + IDX_W'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_value_q <= 1'b0;
			hdr_idx_q  <= '0;
		end else if (accept) begin
			in_value_q <= in_value_d;
			hdr_idx_q  <= hdr_idx_d;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			len_q  <= len_d;
			left_q <= left_d;
		end
	end

	assign q_wr.push  = accept;
	assign q_wr.entry = ent;

endmodule

// ----- hw/rtl/tlvd_queue.sv -----
// ----------------------------------------------------------------------------
// tlvd_queue
// Short FIFO of classified words between the front and the back.
// ----------------------------------------------------------------------------
module tlvd_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  tlvd_pkg::q_wr_t q_wr,
	input  logic            pop,
	output logic            full,
	output tlvd_pkg::q_rd_t q_rd
);
	import tlvd_pkg::*;

	entry_t            mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [QCNT_W-1:0] cnt_q;

	assign full         = (cnt_q == QCNT_W'(QUEUE_DEPTH));
	assign q_rd.not_empty = (cnt_q != '0);
	assign q_rd.entry   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (q_wr.push) begin
			mem_q[wr_ptr_q] <= q_wr.entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (q_wr.push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + QPTR_W'(1);
			end
			cnt_q <= cnt_q + QCNT_W'(q_wr.push) - QCNT_W'(pop);
		end
	end

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		!(q_wr.push && full))
		else $error("queue push while full");

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!(pop && !q_rd.not_empty))
		else $error("queue pop while empty");

	a_count_track: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> cnt_q == QCNT_W'($past(cnt_q) + QCNT_W'($past(q_wr.push))
			- QCNT_W'($past(pop))))
		else $error("queue count out of step with push/pop");

endmodule

// ----- hw/rtl/tlvd_back.sv -----
// ----------------------------------------------------------------------------
// tlvd_back
// Executes queued words: assembles type, checks size, drives result register.
// ----------------------------------------------------------------------------
module tlvd_back (
	input  logic                        clk,
	input  logic                        arst_n,
	input  tlvd_pkg::q_rd_t             q_rd,
	input  logic [tlvd_pkg::CFG_W-1:0]  max_frame_len,
	input  logic                        out_stall,
	output logic                        pop,
	output logic                        out_valid,
	output logic                        kind,
	output logic [tlvd_pkg::TYPE_W-1:0] frame_type,
	output logic [tlvd_pkg::LEN_W-1:0]  value_length,
	output logic [tlvd_pkg::BYTE_W-1:0] data_byte,
	output logic                        last_of_frame,
	output logic                        too_long
);
	import tlvd_pkg::*;

	logic [TYPE_W-1:0] type_q, type_base;
	logic [LEN_W-1:0]  len_q;
	logic              tl_q, tl_now;
	logic              out_valid_q;
	logic              slot_free;
	logic              emits;
	entry_t            e;

	assign e         = q_rd.entry;
	assign slot_free = !out_valid_q || !out_stall;
	assign emits     = (e.op != OP_HDR);
	assign pop       = q_rd.not_empty && (!emits || slot_free);

	always_comb begin
		type_base = (e.idx == '0) ? '0 : type_q;
		for (int k = 0; k < TYPE_KEEP; k++) begin
			if (e.idx == IDX_W'(k)) begin
				type_base[k*BYTE_W +: BYTE_W] = e.data;
			end
		end
	end

	// header plus value length, one bit wider so a huge length cannot wrap
	assign tl_now = (({1'b0, e.len} + (LEN_W+1)'(HDR_BYTES)) > (LEN_W+1)'(max_frame_len));

	always_ff @(posedge clk) begin
		if (pop) begin
			case (e.op)
				OP_HDR: begin
					type_q <= type_base;
				end
				OP_HDR_END: begin
					type_q        <= type_base;
					len_q         <= e.len;
					tl_q          <= tl_now;
					kind          <= KIND_HDR;
					frame_type    <= type_base;
					value_length  <= e.len;
					data_byte     <= '0;
					last_of_frame <= (e.len == '0);
					too_long      <= tl_now;
				end
				OP_VAL, OP_VAL_LAST: begin
					kind          <= KIND_VAL;
					frame_type    <= type_q;
					value_length  <= len_q;
					data_byte     <= e.data;
					last_of_frame <= (e.op == OP_VAL_LAST);
					too_long      <= tl_q;
				end
				default: begin
					type_q <= type_q;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop && emits) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

endmodule

// ----- hw/rtl/tlv_frame_deframer_top.sv -----
// ----------------------------------------------------------------------------
// tlv_frame_deframer_top
// TLV deframer: byte stream in, one header word and one word per value byte out.
// ----------------------------------------------------------------------------
// Frames are 2 type bytes and 4 length bytes, both little-endian, then as
// many value bytes as the length says. Header bytes before the last produce
// no output; the last header byte produces a header word (kind 0) with type,
// length and too_long, where too_long means 6 + length > max_frame_len (the
// frame is still passed through). Each value byte then produces a value word
// (kind 1) repeating type, length and too_long; the final value byte, or the
// header word of a zero-length frame, has last_of_frame set. Throughput is
// one byte per clock while in_stall is low, with no bubbles at frame
// boundaries. Each byte is written into the 4-word queue, then the back end
// loads its word into the output register. The queue decouples the input
// from output stalls: in_stall rises only when it is full. Write
// max_frame_len (reset 4096) only while no frame is in flight.
// ----------------------------------------------------------------------------
module tlv_frame_deframer_top (
	input  logic                        clk,
	input  logic                        arst_n,
	// configuration
	input  logic                        cfg_we,
	input  logic [tlvd_pkg::CFG_W-1:0]  cfg_wdata,
	// input byte stream
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [tlvd_pkg::BYTE_W-1:0] rx_byte,
	// result words
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic                        kind,
	output logic [tlvd_pkg::TYPE_W-1:0] frame_type,
	output logic [tlvd_pkg::LEN_W-1:0]  value_length,
	output logic [tlvd_pkg::BYTE_W-1:0] data_byte,
	output logic                        last_of_frame,
	output logic                        too_long
);
	import tlvd_pkg::*;

	logic [CFG_W-1:0] max_frame_len_q;
	q_wr_t            q_wr;
	q_rd_t            q_rd;
	logic             q_full;
	logic             q_pop;

	// size limit register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_frame_len_q <= CFG_W'(CFG_RESET);
		end else if (cfg_we) begin
			max_frame_len_q <= cfg_wdata;
		end
	end

	assign in_stall = q_full;

	// front: header position, length assembly, value byte count
	tlvd_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.rx_byte  (rx_byte),
		.q_full   (q_full),
		.q_wr     (q_wr)
	);

	tlvd_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.q_wr   (q_wr),
		.pop    (q_pop),
		.full   (q_full),
		.q_rd   (q_rd)
	);

	// back: type assembly, size check, output register
	tlvd_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.q_rd          (q_rd),
		.max_frame_len (max_frame_len_q),
		.out_stall     (out_stall),
		.pop           (q_pop),
		.out_valid     (out_valid),
		.kind          (kind),
		.frame_type    (frame_type),
		.value_length  (value_length),
		.data_byte     (data_byte),
		.last_of_frame (last_of_frame),
		.too_long      (too_long)
	);

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the TLV deframer: byte stream in, header and value
// words out.
// ----------------------------------------------------------------------------
// A short table of hand-picked frames comes first. Its words are typed in
// where they are plain to see, and the rest are predicted. Random well-formed
// frames with random content follow, in phases with different max_frame_len
// settings and different sender gap and receiver stall rates. One phase holds
// the receiver off for a long stretch so that the internal queue fills and
// in_stall rises. The run ends with a frame of maximum length, which can
// never finish, so nothing may follow it.
// ----------------------------------------------------------------------------
module tb_top;
	import tlvd_pkg::*;

	localparam int LIMIT       = 400000; // cycles before the run is called hung
	localparam int SETTLE      = 8;      // quiet cycles after the last word
	localparam int HOLD_CYCLES = 80;     // long receiver hold-off
	localparam int PHASE_BYTES = 80;     // random bytes per phase, roughly
	localparam int N_PHASES    = 6;

	// one output word as the DUT presents it
	typedef struct packed {
		logic              kind;
		logic [TYPE_W-1:0] ftype;
		logic [LEN_W-1:0]  vlen;
		logic [BYTE_W-1:0] data;
		logic              last;
		logic              tlong;
	} word_t;

	// one stimulus byte; when typed is set, want is the word it must produce
	typedef struct packed {
		logic [BYTE_W-1:0] b;
		logic              typed;
		word_t             want;
	} row_t;

	localparam word_t NO_WORD = '0;

	// Rows up to N_LEAD form the opening frames. The rest is the closing
	// frame of maximum length, sent after the random phases.
	localparam int N_LEAD = 21;
	localparam int N_ROWS = 31;
	localparam row_t STIM [N_ROWS] = '{
		// zero-length frame, all-ones type: the header word ends the frame
		'{8'hFF, 1'b0, NO_WORD},
		'{8'hFF, 1'b0, NO_WORD},
		'{8'h00, 1'b0, NO_WORD},
		'{8'h00, 1'b0, NO_WORD},
		'{8'h00, 1'b0, NO_WORD},
		'{8'h00, 1'b1, '{KIND_HDR, 16'hFFFF, 32'h0000_0000, 8'h00, 1'b1, 1'b0}},
		// all-zeros type, one value byte of all ones
		'{8'h00, 1'b0, NO_WORD},
		'{8'h00, 1'b0, NO_WORD},
		'{8'h01, 1'b0, NO_WORD},
		'{8'h00, 1'b0, NO_WORD},
		'{8'h00, 1'b0, NO_WORD},
		'{8'h00, 1'b1, '{KIND_HDR, 16'h0000, 32'h0000_0001, 8'h00, 1'b0, 1'b0}},
		'{8'hFF, 1'b1, '{KIND_VAL, 16'h0000, 32'h0000_0001, 8'hFF, 1'b1, 1'b0}},
		// checkerboard type, two value bytes, back to back with the above
		'{8'h5A, 1'b0, NO_WORD},
		'{8'hA5, 1'b0, NO_WORD},
		'{8'h02, 1'b0, NO_WORD},
		'{8'h00, 1'b0, NO_WORD},
		'{8'h00, 1'b0, NO_WORD},
		'{8'h00, 1'b0, NO_WORD},
		'{8'h00, 1'b0, NO_WORD},
		'{8'h80, 1'b0, NO_WORD},
		// maximum length: too long under any setting, though not if the size sum
		// were to wrap at 32 bits
		'{8'h34, 1'b0, NO_WORD},
		'{8'h12, 1'b0, NO_WORD},
		'{8'hFF, 1'b0, NO_WORD},
		'{8'hFF, 1'b0, NO_WORD},
		'{8'hFF, 1'b0, NO_WORD},
		'{8'hFF, 1'b1, '{KIND_HDR, 16'h1234, 32'hFFFF_FFFF, 8'h00, 1'b0, 1'b1}},
		'{8'h00, 1'b0, NO_WORD},
		'{8'h7F, 1'b0, NO_WORD},
		'{8'h80, 1'b0, NO_WORD},
		'{8'hFF, 1'b0, NO_WORD}
	};

	// per phase: max_frame_len, sender gap %, receiver stall %
	// 6 is the bare header, 0 flags every frame, 65535 is the top of the range
	localparam int PH_MAX  [N_PHASES] = '{6, 0, 12, 20, 9, 65535};
	localparam int PH_GAP  [N_PHASES] = '{0, 50, 0, 34, 0, 34};
	localparam int PH_STALL[N_PHASES] = '{0, 0, 50, 34, 0, 34};
	localparam int HOLD_PHASE = 4;

	logic              clk;
	logic              arst_n    = 1'b0;
	logic              cfg_we    = 1'b0;
	logic [CFG_W-1:0]  cfg_wdata = '0;
	logic              in_valid  = 1'b0;
	logic              in_stall;
	logic [BYTE_W-1:0] rx_byte   = '0;
	logic              out_valid;
	logic              out_stall = 1'b0;
	logic              kind;
	logic [TYPE_W-1:0] frame_type;
	logic [LEN_W-1:0]  value_length;
	logic [BYTE_W-1:0] data_byte;
	logic              last_of_frame;
	logic              too_long;

	tlv_frame_deframer_top dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.rx_byte      (rx_byte),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.kind         (kind),
		.frame_type   (frame_type),
		.value_length (value_length),
		.data_byte    (data_byte),
		.last_of_frame(last_of_frame),
		.too_long     (too_long)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// ------------------------------------------------------------------------
	// Deframer state as the bench tracks it
	// ------------------------------------------------------------------------
	logic              in_payload = 1'b0;
	logic [IDX_W-1:0]  hdr_count  = '0;
	logic [TYPE_W-1:0] cur_type   = '0;
	logic [LEN_W-1:0]  cur_len    = '0;
	logic [LEN_W-1:0]  remaining  = '0;
	logic              cur_long   = 1'b0;
	logic [CFG_W-1:0]  max_len    = CFG_W'(CFG_RESET);

	word_t pending_words[$]; // words owed by the DUT, oldest first
	int    mismatches = 0;
	int    sent_bytes = 0;
	int    gap_pct    = 0;   // sender idle chance per cycle
	int    stall_pct  = 0;   // receiver stall chance per cycle
	bit    hold_start = 1'b0;

	// Advance the tracked state by one byte. Returns 1 when the byte yields a
	// word, which is then in w.
	function automatic bit deframe_byte(input logic [BYTE_W-1:0] b, output word_t w);
		int i;
		w = NO_WORD;
		if (in_payload) begin
			remaining = remaining - 1;
			w = '{KIND_VAL, cur_type, cur_len, b, remaining == 0, cur_long};
			if (remaining == 0) begin
				in_payload = 1'b0;
				hdr_count  = '0;
			end
			return 1'b1;
		end
		if (hdr_count == 0) begin
			cur_type = '0;
			cur_len  = '0;
			cur_long = 1'b0;
		end
		i = int'(hdr_count);
		if (i < TYPE_BYTES) begin
			// type bytes past 16 bits are taken and dropped
			if (i < TYPE_W / BYTE_W)
				cur_type[8*i +: 8] = b;
		end else begin
			cur_len[8*(i-TYPE_BYTES) +: 8] = b;
		end
		hdr_count = hdr_count + 1'b1;
		if (int'(hdr_count) < HDR_BYTES)
			return 1'b0;
		hdr_count = '0;
		// 64-bit sum: a huge length must not wrap to a small size
		cur_long = (64'(HDR_BYTES) + 64'(cur_len)) > 64'(max_len);
		if (cur_len == 0) begin
			w = '{KIND_HDR, cur_type, cur_len, 8'h00, 1'b1, cur_long};
		end else begin
			in_payload = 1'b1;
			remaining  = cur_len;
			w = '{KIND_HDR, cur_type, cur_len, 8'h00, 1'b0, cur_long};
		end
		return 1'b1;
	endfunction

	// ------------------------------------------------------------------------
	// Sender side. Called at a falling edge, returns at a falling edge.
	// valid is set once per step, so a back-to-back byte keeps it high.
	// ------------------------------------------------------------------------
	task automatic send_byte(input logic [BYTE_W-1:0] b, input logic typed, input word_t want);
		word_t w;
		bit    has_word;
		while ($urandom_range(99) < gap_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		rx_byte  <= b;
		do
			@(posedge clk);
		while (in_stall);
		// accepted at this edge
		has_word = deframe_byte(b, w);
		if (typed)
			pending_words.push_back(want);
		else if (has_word)
			pending_words.push_back(w);
		sent_bytes++;
		@(negedge clk);
	endtask

	// one well-formed frame; lengths lean small, zero length is common
	task automatic send_frame();
		logic [31:0]    ty;
		logic [LEN_W-1:0] len;
		int             r;
		r  = $urandom_range(99);
		ty = $urandom();
		if (r < 25)
			len = 0;
		else if (r < 85)
			len = $urandom_range(12, 1);
		else
			len = $urandom_range(40, 13);
		for (int k = 0; k < TYPE_BYTES; k++)
			send_byte(ty[8*k +: 8], 1'b0, NO_WORD);
		for (int k = 0; k < LENGTH_BYTES; k++)
			send_byte(len[8*k +: 8], 1'b0, NO_WORD);
		for (int k = 0; k < int'(len); k++)
			send_byte(8'($urandom_range(255)), 1'b0, NO_WORD);
	endtask

	// wait until every owed word is out, then let the pipe go quiet
	task automatic settle();
		while (pending_words.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
		@(negedge clk);
	endtask

	// register write, only while the block is idle
	task automatic write_max_len(input logic [CFG_W-1:0] v);
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		max_len = v;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// ------------------------------------------------------------------------
	// Receiver side: random stall, plus one long hold-off on request
	// ------------------------------------------------------------------------
	initial begin : receiver
		int hold_left;
		bit hold_used;
		hold_left = 0;
		hold_used = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_start && !hold_used) begin
				hold_used = 1'b1;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				out_stall <= 1'b1;
				hold_left--;
			end else begin
				out_stall <= ($urandom_range(99) < stall_pct);
			end
		end
	end

	// ------------------------------------------------------------------------
	// Output check: each accepted word against the oldest one owed
	// ------------------------------------------------------------------------
	always @(posedge clk) begin : word_check
		word_t got;
		word_t want;
		if (arst_n && out_valid && !out_stall) begin
			got = '{kind, frame_type, value_length, data_byte, last_of_frame, too_long};
			if (pending_words.size() == 0) begin
				$display("%0t: unexpected word kind=%0d type=%h len=%h data=%h last=%0d too_long=%0d",
					$time, got.kind, got.ftype, got.vlen, got.data, got.last, got.tlong);
				mismatches++;
			end else begin
				want = pending_words.pop_front();
				if (got !== want) begin
					$display("%0t: word mismatch", $time);
					$display("  expected kind=%0d type=%h len=%h data=%h last=%0d too_long=%0d",
						want.kind, want.ftype, want.vlen, want.data, want.last, want.tlong);
					$display("  actual   kind=%0d type=%h len=%h data=%h last=%0d too_long=%0d",
						got.kind, got.ftype, got.vlen, got.data, got.last, got.tlong);
					mismatches++;
				end
			end
		end
	end

	// hang guard
	initial begin : watchdog
		int cycles;
		cycles = 0;
		while (cycles < LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("*** FAILED ***");
		$finish;
	end

	// ------------------------------------------------------------------------
	// Test sequence
	// ------------------------------------------------------------------------
	initial begin : stimulus
		int start_cnt;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// opening frames at the reset setting, no idling
		for (int i = 0; i < N_LEAD; i++)
			send_byte(STIM[i].b, STIM[i].typed, STIM[i].want);
		in_valid <= 1'b0;
		settle();

		for (int p = 0; p < N_PHASES; p++) begin
			write_max_len(CFG_W'(PH_MAX[p]));
			gap_pct   = PH_GAP[p];
			stall_pct = PH_STALL[p];
			// receiver goes dark while the sender keeps pushing
			if (p == HOLD_PHASE)
				hold_start = 1'b1;
			start_cnt = sent_bytes;
			while (sent_bytes - start_cnt < PHASE_BYTES)
				send_frame();
			// the endless frame goes last, under the widest setting
			if (p == N_PHASES - 1) begin
				for (int i = N_LEAD; i < N_ROWS; i++)
					send_byte(STIM[i].b, STIM[i].typed, STIM[i].want);
			end
			in_valid <= 1'b0;
			settle();
		end

		if (mismatches == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
